@@ hw/rtl/pqkc_pkg.sv @@
// shared types and codes for the positional queue with key count
`timescale 1ns / 1ps
`default_nettype none
package pqkc_pkg;

    localparam logic [2:0] CMD_APPEND = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_INSERT = 3'd2;
    localparam logic [2:0] CMD_DELETE = 3'd3;
    localparam logic [2:0] CMD_COUNT  = 3'd4;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_TALLY = 1'b1
    } t_state;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] train_number;
        logic [7:0]  position;
    } t_in;

    typedef struct packed {
        logic [1:0] op_status;
        logic [4:0] match_count;
        logic [4:0] list_length;
    } t_out;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic        ins;
        logic        del;
        logic [7:0]  at;
        logic [7:0]  occ;
        logic [15:0] train;
    } t_cell_ctrl;

endpackage
`default_nettype wire

@@ hw/rtl/positional_queue_with_key_count_core.sv @@
// append, remove, insert and delete: the result is registered and valid in the cycle after the transfer
// count: the tally adds eight match bits per cycle; the result is registered once it is done and the output is free
// throughput: one command per cycle while the output is not stalled, except count, which holds the input for its tally
// a result waits in an output register; while it is stalled there, no new command is taken
// reset (synchronous, active low) empties the list; slot contents stay undefined
`timescale 1ns / 1ps
`default_nettype none
module positional_queue_with_key_count_core #(
    parameter int DEPTH = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  pqkc_pkg::t_in     i_in_data,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output pqkc_pkg::t_out    o_out_data
);
    localparam int CW = $clog2(DEPTH + 1);

    pqkc_pkg::t_state     r_state, n_state;
    logic [CW-1:0]        r_occ, n_occ;
    logic                 r_out_valid, n_out_valid;
    pqkc_pkg::t_out       r_out, n_out;
    pqkc_pkg::t_cell_ctrl w_ctrl;
    pqkc_pkg::t_status    w_status;

    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_count_go;
    logic [8:0]           w_occ9;
    logic [8:0]           w_pos9;
    logic [8:0]           w_len9;
    logic [8:0]           w_cnt9;
    logic [15:0]          w_data  [DEPTH];
    logic [DEPTH-1:0]     w_match;
    logic                 w_tally_done;
    logic [CW-1:0]        w_tally_count;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == pqkc_pkg::S_IDLE) && w_out_free);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_occ == CW'(DEPTH));
    assign w_empty    = (r_occ == '0);
    assign w_occ9     = 9'(r_occ);
    assign w_pos9     = 9'(i_in_data.position);
    assign w_cnt9     = 9'(w_tally_count);

    // command decode
    always_comb begin
        w_ctrl.ins   = 1'b0;
        w_ctrl.del   = 1'b0;
        w_ctrl.at    = 8'(r_occ);
        w_ctrl.occ   = 8'(r_occ);
        w_ctrl.train = i_in_data.train_number;
        w_status     = pqkc_pkg::ST_OK;
        w_count_go   = 1'b0;
        case (i_in_data.cmd)
            pqkc_pkg::CMD_APPEND: begin
                if (w_full) begin
                    w_status = pqkc_pkg::ST_FULL;
                end else begin
                    w_ctrl.ins = w_accept;
                end
            end
            pqkc_pkg::CMD_REMOVE: begin
                if (w_empty) begin
                    w_status = pqkc_pkg::ST_EMPTY;
                end else begin
                    w_ctrl.del = w_accept;
                    w_ctrl.at  = 8'd0;
                end
            end
            pqkc_pkg::CMD_INSERT: begin
                if (w_pos9 == 9'd0 || w_pos9 > w_occ9 + 9'd1) begin
                    w_status = pqkc_pkg::ST_BADPOS;
                end else if (w_full) begin
                    w_status = pqkc_pkg::ST_FULL;
                end else begin
                    w_ctrl.ins = w_accept;
                    w_ctrl.at  = i_in_data.position - 8'd1;
                end
            end
            pqkc_pkg::CMD_DELETE: begin
                if (w_empty) begin
                    w_status = pqkc_pkg::ST_EMPTY;
                end else if (w_pos9 == 9'd0 || w_pos9 > w_occ9) begin
                    w_status = pqkc_pkg::ST_BADPOS;
                end else begin
                    w_ctrl.del = w_accept;
                    w_ctrl.at  = i_in_data.position - 8'd1;
                end
            end
            pqkc_pkg::CMD_COUNT: begin
                if (w_empty) begin
                    w_status = pqkc_pkg::ST_EMPTY;
                end else begin
                    w_count_go = w_accept;
                end
            end
            default: begin
            end
        endcase
    end

    // list length after this command
    always_comb begin
        n_occ = r_occ;
        if (w_ctrl.ins) begin
            n_occ = r_occ + 1'b1;
        end else if (w_ctrl.del) begin
            n_occ = r_occ - 1'b1;
        end
    end
    assign w_len9 = 9'(n_occ);

    // state and result register control
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        case (r_state)
            pqkc_pkg::S_IDLE: begin
                if (w_count_go) begin
                    n_state = pqkc_pkg::S_TALLY;
                end else if (w_accept) begin
                    n_out_valid           = 1'b1;
                    n_out.op_status       = w_status;
                    n_out.match_count     = 5'd0;
                    n_out.list_length     = w_len9[4:0];
                end
            end
            pqkc_pkg::S_TALLY: begin
                if (w_tally_done && w_out_free) begin
                    n_state               = pqkc_pkg::S_IDLE;
                    n_out_valid           = 1'b1;
                    n_out.op_status       = pqkc_pkg::ST_OK;
                    n_out.match_count     = w_cnt9[4:0];
                    n_out.list_length     = w_occ9[4:0];
                end
            end
            default: begin
                n_state = pqkc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pqkc_pkg::S_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // chain of slots, head at index 0
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [15:0] w_left;
        logic [15:0] w_right;
        if (g == 0) begin : g_head
            assign w_left = 16'd0;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_right = 16'd0;
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end
        pqkc_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g]),
            .o_match (w_match[g])
        );
    end

    pqkc_tally #(
        .DEPTH (DEPTH)
    ) u_tally (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_count_go),
        .i_bits  (w_match),
        .o_done  (w_tally_done),
        .o_count (w_tally_count)
    );

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(DEPTH))
        else $error("occupancy above depth");

    a_tally_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pqkc_pkg::S_TALLY |-> o_in_stall)
        else $error("transfer taken during tally");

    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_count_go |=> o_out_valid)
        else $error("result missing after command");

    a_len_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> r_occ == $past(r_occ))
        else $error("length changed without a command");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/pqkc_cell.sv @@
// one list slot: holds a train number, shifts with its neighbors, compares to the key
`timescale 1ns / 1ps
`default_nettype none
module pqkc_cell #(
    parameter int IDX = 0
) (
    input  wire                     i_clk,
    input  pqkc_pkg::t_cell_ctrl    i_ctrl,
    input  wire  [15:0]             i_left,
    input  wire  [15:0]             i_right,
    output logic [15:0]             o_data,
    output logic                    o_match
);
    localparam logic [7:0] ME = 8'(IDX);

    logic [15:0] r_data;
    logic [15:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.ins) begin
            if (ME == i_ctrl.at) begin
                n_data = i_ctrl.train;
            end else if (ME > i_ctrl.at) begin
                n_data = i_left;
            end
        end else if (i_ctrl.del) begin
            if (ME >= i_ctrl.at) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = (ME < i_ctrl.occ) && (r_data == i_ctrl.train);

endmodule
`default_nettype wire

@@ hw/rtl/pqkc_tally.sv @@
// adds up the captured match bits, eight per cycle
`timescale 1ns / 1ps
`default_nettype none
module pqkc_tally #(
    parameter  int DEPTH = 16,
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_load,
    input  wire  [DEPTH-1:0]  i_bits,
    output logic              o_done,
    output logic [CW-1:0]     o_count
);
    localparam int STEPS = (DEPTH + 7) / 8;
    localparam int VW    = STEPS * 8;
    localparam int SW    = $clog2(STEPS + 1);

    logic [VW-1:0] r_vec;
    logic [SW-1:0] r_left;
    logic [CW-1:0] r_count;
    logic [3:0]    w_pc;

    always_comb begin
        w_pc = 4'd0;
        for (int k = 0; k < 8; k++) begin
            w_pc = w_pc + 4'(r_vec[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_load) begin
            r_left <= SW'(STEPS);
        end else if (r_left != '0) begin
            r_left <= r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_vec   <= VW'(i_bits);
            r_count <= '0;
        end else if (r_left != '0) begin
            r_vec   <= r_vec >> 8;
            r_count <= r_count + CW'(w_pc);
        end
    end

    assign o_done  = (r_left == '0);
    assign o_count = r_count;

endmodule
`default_nettype wire
